// ===== hw/rtl/gmc_pkg.sv =====
package gmc_pkg;

  // Pipeline depth: six compute stages and the output register
  localparam int NSTAGE = 7;

  localparam logic [21:0] MJD_MAX  = 22'd2973483;
  localparam logic [13:0] YEAR_MIN = 14'd1858;
  localparam logic [13:0] YEAR_MAX = 14'd9999;

  // Day count of 1858-11-17 in the shifted calendar used by the date path
  localparam logic [23:0] MJD_EPOCH = 24'd3600822;

  // Offset from MJD to the day count used by the inverse path
  localparam logic [21:0] MJD_TO_B = 22'd2401526;
  localparam logic [21:0] W_BIAS   = 22'd2131139;

  // Reciprocal for divide by 100: exact for any value below 2**15
  localparam int          DIV100_SH = 21;
  localparam logic [14:0] DIV100_K  = 15'(((64'd1 << DIV100_SH) + 64'd99) / 64'd100);

  // Reciprocal for (4Z - 7468865) / 146097, folded onto MJD
  localparam int          W_SH  = 42;
  localparam logic [63:0] W_K   = ((64'd1 << W_SH) + 64'd146096) / 64'd146097;
  localparam logic [26:0] W_K4  = 27'(64'd4 * W_K);
  localparam logic [49:0] W_OFS = 50'(64'(W_BIAS) * W_K);

  // Reciprocal for (20B - 2442) / 7305, folded onto B
  localparam int          C_SH   = 40;
  localparam logic [63:0] C_K    = ((64'd1 << C_SH) + 64'd7304) / 64'd7305;
  localparam logic [31:0] C_K20  = 32'(64'd20 * C_K);
  localparam logic [54:0] C_OFS  = 55'(64'd2442 * C_K);

  // Reciprocal for 10000 (B - D) / 306001, exact for B - D below 1024
  localparam int          E_SH = 29;
  localparam logic [24:0] E_K  = 25'((64'd10000 * (64'd1 << E_SH) + 64'd306000) / 64'd306001);

  localparam logic [10:0] DAYS_4Y = 11'd1461;

  // Stage load enables shared by all datapath slices
  typedef struct packed {
    logic [NSTAGE-1:0] en;
  } pipe_ctrl_t;

  // Gregorian leap rule; century test reads the fraction of the reciprocal product
  function automatic logic is_leap(input logic [13:0] y);
    logic [28:0] p;
    logic        cent;
    p    = 29'(y) * 29'(DIV100_K);
    cent = (p[DIV100_SH-1:0] < DIV100_SH'(DIV100_K));
    return (y[1:0] == 2'd0) && (!cent || (p[DIV100_SH+1:DIV100_SH] == 2'd0));
  endfunction

  function automatic logic [8:0] div100(input logic [14:0] y);
    logic [29:0] p;
    p = 30'(y) * 30'(DIV100_K);
    return 9'(p >> DIV100_SH);
  endfunction

  // Days from 1 March to the first of the month (year starting in March)
  function automatic logic [8:0] month_offset(input logic [3:0] m);
    case (m)
      4'd1:    return 9'd306;
      4'd2:    return 9'd337;
      4'd3:    return 9'd0;
      4'd4:    return 9'd31;
      4'd5:    return 9'd61;
      4'd6:    return 9'd92;
      4'd7:    return 9'd122;
      4'd8:    return 9'd153;
      4'd9:    return 9'd184;
      4'd10:   return 9'd214;
      4'd11:   return 9'd245;
      4'd12:   return 9'd275;
      default: return 9'd0;
    endcase
  endfunction

  // Month length, February as 28
  function automatic logic [4:0] month_len(input logic [3:0] m);
    case (m)
      4'd2:                   return 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11: return 5'd30;
      default:                return 5'd31;
    endcase
  endfunction

  // floor(30.6001 * e)
  function automatic logic [8:0] month_days(input logic [4:0] e);
    case (e)
      5'd1:    return 9'd30;
      5'd2:    return 9'd61;
      5'd3:    return 9'd91;
      5'd4:    return 9'd122;
      5'd5:    return 9'd153;
      5'd6:    return 9'd183;
      5'd7:    return 9'd214;
      5'd8:    return 9'd244;
      5'd9:    return 9'd275;
      5'd10:   return 9'd306;
      5'd11:   return 9'd336;
      5'd12:   return 9'd367;
      5'd13:   return 9'd397;
      5'd14:   return 9'd428;
      5'd15:   return 9'd459;
      5'd16:   return 9'd489;
      default: return 9'd0;
    endcase
  endfunction

endpackage

// ===== hw/rtl/gregorian_mjd_converter.sv =====
// Channel  | Handshake                 | Word
// ---------+---------------------------+--------------------------------------------
// input    | in_valid_i / in_ready_o   | command, in_year, in_month, in_day,
//          |                           | in_day_number
// output   | out_valid_o / out_ready_i | out_day_number, out_year, out_month,
//          |                           | out_day, leap, invalid
//
// One word per cycle sustained while out_ready_i holds high; a word passes through six compute
// stages and the output register, a depth set by the chain of reciprocal multiplies of the inverse path.
// Reset clears the stage valid bits only.
// A stalled output holds a full stage only when every later stage is full; the other stages keep moving.
module gregorian_mjd_converter
  import gmc_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        command_i,
  input  logic [13:0] in_year_i,
  input  logic [3:0]  in_month_i,
  input  logic [4:0]  in_day_i,
  input  logic [21:0] in_day_number_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [21:0] out_day_number_o,
  output logic [13:0] out_year_o,
  output logic [3:0]  out_month_o,
  output logic [4:0]  out_day_o,
  output logic        leap_o,
  output logic        invalid_o
);

  localparam int NECHO = NSTAGE - 1;

  typedef struct packed {
    logic        cmd;
    logic [13:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
    logic [21:0] day_number;
  } echo_t;

  logic [NSTAGE-1:0] vld_q, vld_d;
  logic [NSTAGE-1:0] rdy;
  pipe_ctrl_t        ctrl;

  echo_t       echo_q [NECHO];
  logic [21:0] dn0;
  logic        bad0;
  logic [13:0] y1;
  logic [3:0]  m1;
  logic [4:0]  d1;
  logic        bad1;

  logic [21:0] dn_d;
  logic [13:0] y_d;
  logic [3:0]  m_d;
  logic [4:0]  d_d;
  logic        leap_d, inv_d;

  logic [21:0] dn_q;
  logic [13:0] y_q;
  logic [3:0]  m_q;
  logic [4:0]  d_q;
  logic        leap_q, inv_q;

  // Stage ready chain: a stage loads when empty or when its successor moves
  always_comb begin
    rdy[NSTAGE-1] = !vld_q[NSTAGE-1] || out_ready_i;
    for (int k = NSTAGE - 2; k >= 0; k--) begin
      rdy[k] = !vld_q[k] || rdy[k+1];
    end
    ctrl.en = rdy;
  end

  // Valid bits travel with the words
  always_comb begin
    vld_d[0] = rdy[0] ? in_valid_i : vld_q[0];
    for (int k = 1; k < NSTAGE; k++) begin
      vld_d[k] = rdy[k] ? vld_q[k-1] : vld_q[k];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= vld_d;
    end
  end

  assign in_ready_o  = rdy[0];
  assign out_valid_o = vld_q[NSTAGE-1];

  // Echoed input fields
  always_ff @(posedge clk_i) begin
    if (rdy[0]) begin
      echo_q[0] <= '{cmd: command_i, year: in_year_i, month: in_month_i,
                     day: in_day_i, day_number: in_day_number_i};
    end
  end
  for (genvar k = 1; k < NECHO; k++) begin : g_echo
    always_ff @(posedge clk_i) begin
      if (rdy[k]) echo_q[k] <= echo_q[k-1];
    end
  end

  gmc_date_path u_date (
    .clk_i        (clk_i),
    .ctrl_i       (ctrl),
    .year_i       (in_year_i),
    .month_i      (in_month_i),
    .day_i        (in_day_i),
    .day_number_o (dn0),
    .bad_o        (bad0)
  );

  gmc_mjd_path u_mjd (
    .clk_i        (clk_i),
    .ctrl_i       (ctrl),
    .day_number_i (in_day_number_i),
    .year_o       (y1),
    .month_o      (m1),
    .day_o        (d1),
    .bad_o        (bad1)
  );

  // Merge the two directions and derive the leap flag
  always_comb begin
    if (!echo_q[NECHO-1].cmd) begin
      dn_d  = bad0 ? 22'd0 : dn0;
      y_d   = echo_q[NECHO-1].year;
      m_d   = echo_q[NECHO-1].month;
      d_d   = echo_q[NECHO-1].day;
      inv_d = bad0;
    end else begin
      dn_d  = echo_q[NECHO-1].day_number;
      y_d   = bad1 ? 14'd0 : y1;
      m_d   = bad1 ? 4'd0 : m1;
      d_d   = bad1 ? 5'd0 : d1;
      inv_d = bad1;
    end
    leap_d = is_leap(y_d) && !(echo_q[NECHO-1].cmd && bad1);
  end

  // Output register
  always_ff @(posedge clk_i) begin
    if (rdy[NSTAGE-1]) begin
      dn_q   <= dn_d;
      y_q    <= y_d;
      m_q    <= m_d;
      d_q    <= d_d;
      leap_q <= leap_d;
      inv_q  <= inv_d;
    end
  end

  assign out_day_number_o = dn_q;
  assign out_year_o       = y_q;
  assign out_month_o      = m_q;
  assign out_day_o        = d_q;
  assign leap_o           = leap_q;
  assign invalid_o        = inv_q;

endmodule

// ===== hw/rtl/gmc_date_path.sv =====
module gmc_date_path
  import gmc_pkg::*;
(
  input  logic        clk_i,
  input  pipe_ctrl_t  ctrl_i,
  input  logic [13:0] year_i,
  input  logic [3:0]  month_i,
  input  logic [4:0]  day_i,
  output logic [21:0] day_number_o,
  output logic        bad_o
);

  // Stage 1 registers
  logic [14:0] yadj_q, yadj_d;
  logic [8:0]  ycent_q;
  logic        leap_q;
  logic        rng_ok_q, rng_ok_d;
  logic [8:0]  moff_q;
  logic [4:0]  mlen_q;
  logic        feb_q;
  logic [4:0]  day_q;

  // Stage 2 and delay line up to stage 6
  localparam int NDLY = 5;
  logic [21:0] dn_q  [NDLY];
  logic        bad_q [NDLY];
  logic [21:0] dn_d;
  logic        bad_d;

  // Stage 1: shifted year, century count, range checks, month tables
  always_comb begin
    yadj_d   = 15'(year_i) + 15'd8000 - 15'(month_i < 4'd3);
    rng_ok_d = (year_i >= YEAR_MIN) && (year_i <= YEAR_MAX) &&
               (month_i >= 4'd1) && (month_i <= 4'd12) && (day_i != 5'd0);
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.en[0]) begin
      yadj_q   <= yadj_d;
      ycent_q  <= div100(yadj_d);
      leap_q   <= is_leap(year_i);
      rng_ok_q <= rng_ok_d;
      moff_q   <= month_offset(month_i);
      mlen_q   <= month_len(month_i);
      feb_q    <= (month_i == 4'd2);
      day_q    <= day_i;
    end
  end

  // Stage 2: day count and validity
  always_comb begin
    logic [23:0] t;
    logic [4:0]  len;
    t = 24'(yadj_q) * 24'd365 + 24'(yadj_q >> 2) - 24'(ycent_q) + 24'(ycent_q >> 2)
        + 24'(moff_q) + 24'(day_q);
    len   = (feb_q && leap_q) ? 5'd29 : mlen_q;
    bad_d = !rng_ok_q || (day_q > len) || (t < MJD_EPOCH);
    dn_d  = 22'(t - MJD_EPOCH);
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.en[1]) begin
      dn_q[0]  <= dn_d;
      bad_q[0] <= bad_d;
    end
  end

  // Hold alongside the inverse path
  for (genvar k = 1; k < NDLY; k++) begin : g_dly
    always_ff @(posedge clk_i) begin
      if (ctrl_i.en[k+1]) begin
        dn_q[k]  <= dn_q[k-1];
        bad_q[k] <= bad_q[k-1];
      end
    end
  end

  assign day_number_o = dn_q[NDLY-1];
  assign bad_o        = bad_q[NDLY-1];

endmodule

// ===== hw/rtl/gmc_mjd_path.sv =====
module gmc_mjd_path
  import gmc_pkg::*;
(
  input  logic        clk_i,
  input  pipe_ctrl_t  ctrl_i,
  input  logic [21:0] day_number_i,
  output logic [13:0] year_o,
  output logic [3:0]  month_o,
  output logic [4:0]  day_o,
  output logic        bad_o
);

  localparam int NBAD = 6;

  logic        bad_q [NBAD];
  logic [6:0]  w_q;
  logic [21:0] dn_q;
  logic [22:0] b2_q, b3_q, b4_q;
  logic [13:0] c3_q, c4_q, c5_q;
  logic [22:0] d4_q;
  logic [9:0]  bd5_q;
  logic [4:0]  e5_q;
  logic [13:0] y6_q;
  logic [3:0]  m6_q;
  logic [4:0]  d6_q;

  logic [49:0] wp;
  logic [22:0] b_d;
  logic [54:0] cp;
  logic [24:0] dp;
  logic [9:0]  bd_d;
  logic [34:0] ep;
  logic [8:0]  f;
  logic [3:0]  m_d;

  // Range flag rides along with the word
  always_ff @(posedge clk_i) begin
    if (ctrl_i.en[0]) bad_q[0] <= (day_number_i > MJD_MAX);
  end
  for (genvar k = 1; k < NBAD; k++) begin : g_bad
    always_ff @(posedge clk_i) begin
      if (ctrl_i.en[k]) bad_q[k] <= bad_q[k-1];
    end
  end

  // Stage 1: century term W
  assign wp = 50'(day_number_i) * 50'(W_K4) + W_OFS;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.en[0]) begin
      w_q  <= 7'(wp >> W_SH);
      dn_q <= day_number_i;
    end
  end

  // Stage 2: B = Z + 1 + W - W/4 + 1524
  assign b_d = 23'(dn_q) + 23'(MJD_TO_B) + 23'(w_q) - 23'(w_q >> 2);

  always_ff @(posedge clk_i) begin
    if (ctrl_i.en[1]) b2_q <= b_d;
  end

  // Stage 3: C = (20B - 2442) / 7305
  assign cp = 55'(b2_q) * 55'(C_K20) - C_OFS;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.en[2]) begin
      c3_q <= 14'(cp >> C_SH);
      b3_q <= b2_q;
    end
  end

  // Stage 4: D = 1461C / 4
  assign dp = 25'(c3_q) * 25'(DAYS_4Y);

  always_ff @(posedge clk_i) begin
    if (ctrl_i.en[3]) begin
      d4_q <= 23'(dp >> 2);
      c4_q <= c3_q;
      b4_q <= b3_q;
    end
  end

  // Stage 5: E = 10000(B - D) / 306001
  assign bd_d = 10'(b4_q - d4_q);
  assign ep   = 35'(bd_d) * 35'(E_K);

  always_ff @(posedge clk_i) begin
    if (ctrl_i.en[4]) begin
      bd5_q <= bd_d;
      e5_q  <= 5'(ep >> E_SH);
      c5_q  <= c4_q;
    end
  end

  // Stage 6: day, month and year
  assign f   = month_days(e5_q);
  assign m_d = (e5_q >= 5'd14) ? 4'(e5_q - 5'd13) : 4'(e5_q - 5'd1);

  always_ff @(posedge clk_i) begin
    if (ctrl_i.en[5]) begin
      d6_q <= 5'(bd5_q - 10'(f));
      m6_q <= m_d;
      y6_q <= (m_d <= 4'd2) ? (c5_q - 14'd4715) : (c5_q - 14'd4716);
    end
  end

  assign year_o  = y6_q;
  assign month_o = m6_q;
  assign day_o   = d6_q;
  assign bad_o   = bad_q[NBAD-1];

endmodule

// ===== verif/tb_gregorian_mjd_converter.sv =====
`timescale 1ns / 100ps

module tb_gregorian_mjd_converter;

  localparam logic      CMD_TO_MJD  = 1'b0;
  localparam logic      CMD_TO_DATE = 1'b1;
  localparam int        FIRST_YEAR  = 1858;
  localparam int        LAST_YEAR   = 9999;
  localparam int        LAST_MJD    = 2973483;
  localparam int        RANDOM_WORDS = 1650;

  // One input word and one result word
  typedef struct packed {
    logic        cmd;
    logic [13:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
    logic [21:0] dn;
  } date_word_t;

  typedef struct packed {
    logic [21:0] mjd;
    logic [13:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
    logic        leap;
    logic        invalid;
  } mjd_result_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic        in_valid = 1'b0;
  logic        in_ready;
  date_word_t  shown = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  mjd_result_t got;

  date_word_t  words_to_send[$];
  mjd_result_t results_due[$];
  mjd_result_t due_now;
  int          mismatches = 0;
  int          cycle_count = 0;

  gregorian_mjd_converter u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid),
    .in_ready_o      (in_ready),
    .command_i       (shown.cmd),
    .in_year_i       (shown.year),
    .in_month_i      (shown.month),
    .in_day_i        (shown.day),
    .in_day_number_i (shown.dn),
    .out_valid_o     (out_valid),
    .out_ready_i     (out_ready),
    .out_day_number_o(got.mjd),
    .out_year_o      (got.year),
    .out_month_o     (got.month),
    .out_day_o       (got.day),
    .leap_o          (got.leap),
    .invalid_o       (got.invalid)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
  end

  // A window with no idling on either side
  function automatic logic steady_phase();
    return (cycle_count >= 600) && (cycle_count < 1100);
  endfunction

  function automatic logic gregorian_leap(longint y);
    return (y % 400 == 0) || ((y % 100 != 0) && (y % 4 == 0));
  endfunction

  function automatic longint days_in_month(longint y, longint m);
    case (m)
      2:             return gregorian_leap(y) ? 29 : 28;
      4, 6, 9, 11:   return 30;
      default:       return 31;
    endcase
  endfunction

  // Expected result word for one input word
  function automatic mjd_result_t predict_conversion(date_word_t w);
    mjd_result_t r;
    longint      yy, mm, dd, s, z, wq, a, b, c, d, e, f;
    logic        bad;
    r   = '0;
    bad = 1'b0;
    if (w.cmd == CMD_TO_MJD) begin
      r.year  = w.year;
      r.month = w.month;
      r.day   = w.day;
      yy = longint'(w.year);
      mm = longint'(w.month);
      dd = longint'(w.day);
      if (yy < FIRST_YEAR || yy > LAST_YEAR || mm < 1 || mm > 12 ||
          dd < 1 || dd > days_in_month(yy, mm)) begin
        bad = 1'b1;
      end else begin
        yy = yy + 8000;
        if (mm < 3) begin
          yy = yy - 1;
          mm = mm + 12;
        end
        s = yy * 365 + yy / 4 - yy / 100 + yy / 400 - 1200820
            + (mm * 153 + 3) / 5 - 92 + dd - 1 - 2400001;
        // dates before the epoch give a negative count
        if (s < 0) bad = 1'b1;
        else r.mjd = 22'(s);
      end
      r.leap = gregorian_leap(longint'(r.year));
    end else begin
      r.mjd = w.dn;
      if (longint'(w.dn) > LAST_MJD) begin
        bad = 1'b1;
      end else begin
        z  = longint'(w.dn) + 2400001;
        wq = (4 * z - 7468865) / 146097;
        a  = z + 1 + wq - wq / 4;
        b  = a + 1524;
        c  = (20 * b - 2442) / 7305;
        d  = (1461 * c) / 4;
        e  = (10000 * (b - d)) / 306001;
        f  = (306001 * e) / 10000;
        mm = (e >= 14) ? e - 13 : e - 1;
        r.day   = 5'(b - d - f);
        r.month = 4'(mm);
        r.year  = 14'((mm <= 2) ? c - 4715 : c - 4716);
        r.leap  = gregorian_leap(longint'(r.year));
      end
    end
    r.invalid = bad;
    return r;
  endfunction

  function automatic void queue_word(logic cmd, int y, int m, int d, int dn);
    date_word_t w;
    w.cmd   = cmd;
    w.year  = 14'(y);
    w.month = 4'(m);
    w.day   = 5'(d);
    w.dn    = 22'(dn);
    words_to_send.push_back(w);
  endfunction

  // Random well-formed date, biased towards century years and month ends
  task automatic pick_date(output int y, output int m, output int d);
    if ($urandom_range(3) == 0) y = 100 * $urandom_range(19, 99);
    else y = $urandom_range(FIRST_YEAR, LAST_YEAR);
    m = $urandom_range(1, 12);
    if ($urandom_range(3) == 0) d = int'(days_in_month(y, m));
    else d = $urandom_range(1, int'(days_in_month(y, m)));
  endtask

  // Driver: offers the next word once the previous one has gone
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) results_due.push_back(predict_conversion(shown));
      if (!in_valid || in_ready) begin
        if (words_to_send.size() > 0 && (steady_phase() || $urandom_range(99) >= 29)) begin
          shown    <= words_to_send.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: checks each accepted result word against the oldest prediction
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (results_due.size() == 0) begin
          $error("result word with none pending: mjd %0d year %0d", got.mjd, got.year);
          mismatches++;
        end else begin
          due_now = results_due.pop_front();
          if (got.mjd !== due_now.mjd) begin
            $error("out_day_number: expected %0d, got %0d", due_now.mjd, got.mjd);
            mismatches++;
          end
          if (got.year !== due_now.year) begin
            $error("out_year: expected %0d, got %0d", due_now.year, got.year);
            mismatches++;
          end
          if (got.month !== due_now.month) begin
            $error("out_month: expected %0d, got %0d", due_now.month, got.month);
            mismatches++;
          end
          if (got.day !== due_now.day) begin
            $error("out_day: expected %0d, got %0d", due_now.day, got.day);
            mismatches++;
          end
          if (got.leap !== due_now.leap) begin
            $error("leap: expected %0b, got %0b", due_now.leap, got.leap);
            mismatches++;
          end
          if (got.invalid !== due_now.invalid) begin
            $error("invalid: expected %0b, got %0b", due_now.invalid, got.invalid);
            mismatches++;
          end
        end
      end
      out_ready <= steady_phase() || $urandom_range(99) >= 29;
    end
  end

  // Stimulus and end of run
  initial begin
    int        sel, y, m, d, len;
    date_word_t w;
    mjd_result_t r;

    // epoch, range ends and calendar corner cases
    queue_word(CMD_TO_MJD, 1858, 11, 17, 0);
    queue_word(CMD_TO_MJD, 1858, 11, 16, 4194303);
    queue_word(CMD_TO_MJD, 1858, 1, 1, 0);
    queue_word(CMD_TO_MJD, 9999, 12, 31, 4194303);
    queue_word(CMD_TO_MJD, 10000, 1, 1, 0);
    queue_word(CMD_TO_MJD, 1857, 12, 31, 0);
    queue_word(CMD_TO_MJD, 0, 0, 0, 0);
    queue_word(CMD_TO_MJD, 16383, 15, 31, 4194303);
    queue_word(CMD_TO_MJD, 2000, 2, 29, 0);
    queue_word(CMD_TO_MJD, 1900, 2, 29, 0);
    queue_word(CMD_TO_MJD, 2100, 2, 28, 0);
    queue_word(CMD_TO_MJD, 2024, 2, 30, 0);
    queue_word(CMD_TO_MJD, 2023, 4, 31, 0);
    queue_word(CMD_TO_MJD, 2023, 6, 30, 0);
    queue_word(CMD_TO_MJD, 2023, 13, 1, 0);
    queue_word(CMD_TO_MJD, 2023, 1, 0, 0);
    queue_word(CMD_TO_DATE, 0, 0, 0, 0);
    queue_word(CMD_TO_DATE, 16383, 15, 31, 1);
    queue_word(CMD_TO_DATE, 0, 0, 0, LAST_MJD);
    queue_word(CMD_TO_DATE, 16383, 15, 31, LAST_MJD + 1);
    queue_word(CMD_TO_DATE, 0, 0, 0, 4194303);
    queue_word(CMD_TO_DATE, 0, 0, 0, 51603);
    queue_word(CMD_TO_DATE, 0, 0, 0, 51544);
    queue_word(CMD_TO_DATE, 0, 0, 0, 15078);

    // random words: mostly well-formed, some broken, some pure noise
    for (int i = 0; i < RANDOM_WORDS; i++) begin
      w.cmd   = 1'($urandom_range(1));
      w.year  = 14'($urandom_range(0, 16383));
      w.month = 4'($urandom_range(0, 15));
      w.day   = 5'($urandom_range(0, 31));
      w.dn    = 22'($urandom_range(0, 4194303));
      sel = $urandom_range(99);
      if (sel < 40) begin
        pick_date(y, m, d);
        w.cmd   = CMD_TO_MJD;
        w.year  = 14'(y);
        w.month = 4'(m);
        w.day   = 5'(d);
      end else if (sel < 55) begin
        w.cmd = CMD_TO_DATE;
        w.dn  = 22'($urandom_range(0, LAST_MJD));
      end else if (sel < 75) begin
        // day number on or just before a picked date, which is biased towards month ends
        pick_date(y, m, d);
        w.cmd   = CMD_TO_MJD;
        w.year  = 14'(y);
        w.month = 4'(m);
        w.day   = 5'(d);
        r = predict_conversion(w);
        w.cmd = CMD_TO_DATE;
        if (r.invalid || r.mjd == 0) w.dn = 22'($urandom_range(0, 400));
        else w.dn = r.mjd - 22'($urandom_range(1));
      end else if (sel < 85) begin
        // date with one field broken
        pick_date(y, m, d);
        len = int'(days_in_month(y, m));
        case ($urandom_range(2))
          0: d = (len == 31 || $urandom_range(1) == 0) ? 0 : $urandom_range(len + 1, 31);
          1: m = ($urandom_range(1) == 0) ? 0 : $urandom_range(13, 15);
          default: y = ($urandom_range(1) == 0) ? $urandom_range(0, FIRST_YEAR - 1) :
                                                  $urandom_range(LAST_YEAR + 1, 16383);
        endcase
        w.cmd   = CMD_TO_MJD;
        w.year  = 14'(y);
        w.month = 4'(m);
        w.day   = 5'(d);
      end
      words_to_send.push_back(w);
    end

    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    while (words_to_send.size() != 0 || in_valid) @(negedge clk_i);
    while (results_due.size() != 0) @(negedge clk_i);
    repeat (20) @(negedge clk_i);

    if (mismatches == 0) begin
      $display("PASS gregorian_mjd_converter");
    end else begin
      $display("FAIL gregorian_mjd_converter");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #2_000_000;
    $display("FAIL gregorian_mjd_converter");
    $finish;
  end

endmodule
